// File: src/mws_pkg.sv
package mws_pkg;

   localparam int WAITER_DEPTH   = 16;
   localparam int THREAD_ID_BITS = 8;
   localparam int ACTION_BITS    = 3;
   localparam int STATUS_BITS    = 3;

   localparam int PTR_BITS   = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(WAITER_DEPTH + 1);

   localparam logic [ACTION_BITS-1:0] ACT_INIT    = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_LOCK    = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_TRYLOCK = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_UNLOCK  = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_DESTROY = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_BLOCKED   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_BUSY      = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOT_OWNER = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_IN_USE    = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd5;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

// File: src/mws_ctrl.sv
module mws_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output mws_pkg::cmd_type cmd
);
   import mws_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd.load     = 1'b0;
      cmd.exec     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff == S_EXEC);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/mws_dpath.sv
module mws_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  mws_pkg::cmd_type                   cmd,
   input  logic [mws_pkg::ACTION_BITS-1:0]    req_action,
   input  logic [mws_pkg::THREAD_ID_BITS-1:0] req_thread_id,
   output logic [mws_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic                               rsp_wake_valid,
   output logic [mws_pkg::THREAD_ID_BITS-1:0] rsp_wake_thread
);
   import mws_pkg::*;

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(WAITER_DEPTH);

   logic [ACTION_BITS-1:0]    act_ff;
   logic [THREAD_ID_BITS-1:0] tid_ff;

   logic                      held_ff;
   logic                      held_in;
   logic [THREAD_ID_BITS-1:0] owner_ff;
   logic [THREAD_ID_BITS-1:0] owner_in;
   logic [COUNT_BITS-1:0]     count_ff;
   logic [COUNT_BITS-1:0]     count_in;

   logic [THREAD_ID_BITS-1:0] stack_mem [WAITER_DEPTH];
   logic [THREAD_ID_BITS-1:0] rd_data_ff;
   logic [PTR_BITS-1:0]       wr_addr;
   logic [PTR_BITS-1:0]       rd_addr;
   logic                      push;
   logic                      pop;

   logic [STATUS_BITS-1:0]    status_in;
   logic [STATUS_BITS-1:0]    status_ff;
   logic                      wake_ff;

   assign wr_addr = count_ff[PTR_BITS-1:0];
   assign rd_addr = PTR_BITS'(count_ff - COUNT_BITS'(1));

   always_comb begin
      held_in   = held_ff;
      owner_in  = owner_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      push      = 1'b0;
      pop       = 1'b0;
      unique case (act_ff)
         ACT_INIT: begin
            held_in  = 1'b0;
            owner_in = '0;
            count_in = '0;
         end
         ACT_LOCK: begin
            if (!held_ff) begin
               held_in  = 1'b1;
               owner_in = tid_ff;
            end else if (count_ff < FULL_COUNT) begin
               push      = 1'b1;
               count_in  = count_ff + COUNT_BITS'(1);
               status_in = ST_BLOCKED;
            end else begin
               status_in = ST_FULL;
            end
         end
         ACT_TRYLOCK: begin
            if (!held_ff) begin
               held_in  = 1'b1;
               owner_in = tid_ff;
            end else begin
               status_in = ST_BUSY;
            end
         end
         ACT_UNLOCK: begin
            if (!held_ff || owner_ff != tid_ff) begin
               status_in = ST_NOT_OWNER;
            end else begin
               held_in  = 1'b0;
               owner_in = '0;
               if (count_ff != '0) begin
                  pop      = 1'b1;
                  count_in = count_ff - COUNT_BITS'(1);
               end
            end
         end
         ACT_DESTROY: begin
            if (held_ff || count_ff != '0) begin
               status_in = ST_IN_USE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         tid_ff <= req_thread_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         owner_ff <= '0;
         count_ff <= '0;
         wake_ff  <= 1'b0;
      end else if (cmd.exec) begin
         held_ff  <= held_in;
         owner_ff <= owner_in;
         count_ff <= count_in;
         wake_ff  <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
      end
   end

   // The read at the top of the stack runs every execute cycle; its data is
   // only shown when the transaction really popped a waiter.
   always_ff @(posedge clock) begin
      if (cmd.exec && push) begin
         stack_mem[wr_addr] <= tid_ff;
      end
      if (cmd.exec) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_wake_valid  = wake_ff;
   assign rsp_wake_thread = wake_ff ? rd_data_ff : '0;

endmodule

// File: src/mutex_with_waiter_stack_core.sv
// A request is taken at a clock edge where start is high and busy is low; busy
// then stays high while the request executes, and the result appears on the
// rsp_ ports, marked by rsp_valid, for exactly one cycle after that. The
// receiver cannot stall, so results must be captured when rsp_valid is high.
// Busy is already low during the result cycle, so a new request can be taken
// while a result is shown. Each request is first captured and then executed
// against the owner register and the waiter stack, whose registered read port
// supplies the thread to wake on an unlock.
module mutex_with_waiter_stack_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [mws_pkg::ACTION_BITS-1:0]    req_action,
   input  logic [mws_pkg::THREAD_ID_BITS-1:0] req_thread_id,
   output logic                               rsp_valid,
   output logic [mws_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic                               rsp_wake_valid,
   output logic [mws_pkg::THREAD_ID_BITS-1:0] rsp_wake_thread
);
   import mws_pkg::*;

   cmd_type cmd;

   mws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   mws_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_thread_id   (req_thread_id),
      .rsp_status      (rsp_status),
      .rsp_wake_valid  (rsp_wake_valid),
      .rsp_wake_thread (rsp_wake_thread)
   );

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted transaction did not enter execution");

   a_result_follows_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result strobe without a preceding execute cycle");

   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("execute cycle produced no result");

   a_wake_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake_valid |-> rsp_status == ST_OK)
      else $error("wake reported with a failing status");

endmodule

// File: verif/mutex_with_waiter_stack_core_tb.sv
`timescale 1ns / 1ps

module mutex_with_waiter_stack_core_tb;
   import mws_pkg::*;

   localparam int TID_W        = THREAD_ID_BITS;
   localparam int ITEM_TARGET  = 1450;
   localparam int STALL_LIMIT  = 500;
   localparam int DRAIN_LIMIT  = 100;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   wake_valid;
      logic [TID_W-1:0]       wake_thread;
   } mutex_answer_t;

   // Tracks the owner and the waiter stack and holds the answers still due.
   class mutex_shadow;
      bit                  holder_valid = 1'b0;
      logic [TID_W-1:0]    holder = '0;
      logic [TID_W-1:0]    waiters [WAITER_DEPTH];
      int unsigned         waiter_count = 0;
      bit                  last_wake = 1'b0;
      logic [TID_W-1:0]    last_woken = '0;
      mutex_answer_t       due_answers [$];
      int                  error_count = 0;
      int                  request_count = 0;
      int                  answer_count = 0;
      int                  wake_count = 0;
      int                  status_seen [8];

      function new();
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void take_request(logic [ACTION_BITS-1:0] action, logic [TID_W-1:0] tid);
         mutex_answer_t ans;
         ans = '{status: ST_OK, wake_valid: 1'b0, wake_thread: '0};
         case (action)
            ACT_INIT: begin
               holder_valid = 1'b0;
               holder = '0;
               waiter_count = 0;
            end
            ACT_LOCK: begin
               if (!holder_valid) begin
                  holder_valid = 1'b1;
                  holder = tid;
               end else if (waiter_count < WAITER_DEPTH) begin
                  waiters[waiter_count] = tid;
                  waiter_count++;
                  ans.status = ST_BLOCKED;
               end else begin
                  ans.status = ST_FULL;
               end
            end
            ACT_TRYLOCK: begin
               if (!holder_valid) begin
                  holder_valid = 1'b1;
                  holder = tid;
               end else begin
                  ans.status = ST_BUSY;
               end
            end
            ACT_UNLOCK: begin
               if (!holder_valid || holder != tid) begin
                  ans.status = ST_NOT_OWNER;
               end else begin
                  holder_valid = 1'b0;
                  holder = '0;
                  // The most recently queued waiter is the one released.
                  if (waiter_count > 0) begin
                     waiter_count--;
                     ans.wake_valid = 1'b1;
                     ans.wake_thread = waiters[waiter_count];
                  end
               end
            end
            ACT_DESTROY: begin
               if (holder_valid || waiter_count != 0) ans.status = ST_IN_USE;
            end
            default: ;
         endcase
         last_wake = ans.wake_valid;
         last_woken = ans.wake_thread;
         request_count++;
         due_answers.push_back(ans);
      endfunction

      task report_mismatch(string msg);
         error_count++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_answer(logic [STATUS_BITS-1:0] status, logic wake_valid,
                        logic [TID_W-1:0] wake_thread);
         mutex_answer_t want;
         answer_count++;
         if (due_answers.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                      answer_count));
         end else begin
            want = due_answers.pop_front();
            if (status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                         answer_count, status, want.status));
            if (wake_valid !== want.wake_valid)
               report_mismatch($sformatf("result %0d wake_valid %0b, expected %0b",
                                         answer_count, wake_valid, want.wake_valid));
            if (wake_thread !== want.wake_thread)
               report_mismatch($sformatf("result %0d wake_thread %0d, expected %0d",
                                         answer_count, wake_thread, want.wake_thread));
            status_seen[want.status]++;
            if (want.wake_valid) wake_count++;
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [ACTION_BITS-1:0] req_action = ACT_INIT;
   logic [TID_W-1:0]       req_thread_id = '0;
   logic                   rsp_valid;
   logic [STATUS_BITS-1:0] rsp_status;
   logic                   rsp_wake_valid;
   logic [TID_W-1:0]       rsp_wake_thread;

   mutex_shadow shadow;
   bit          steady_flow = 1'b0;

   mutex_with_waiter_stack_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_thread_id   (req_thread_id),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_wake_valid  (rsp_wake_valid),
      .rsp_wake_thread (rsp_wake_thread)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         shadow.check_answer(rsp_status, rsp_wake_valid, rsp_wake_thread);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (rsp_valid === 1'b1 || (start && busy === 1'b0)) quiet = 0;
         else quiet++;
      end
      $display("mutex_with_waiter_stack_core_tb: errors");
      $finish;
   end

   // Presents one request and returns once the block has taken the transaction.
   task issue_request(logic [ACTION_BITS-1:0] action, logic [TID_W-1:0] tid);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_action = action;
      req_thread_id = tid;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      shadow.take_request(action, tid);
   endtask

   task wait_answers_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      start = 1'b0;
      while (shadow.due_answers.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // A realistic contention pattern: an owner, a crowd of waiters, then a chain
   // of hand-overs where each woken thread comes back with a fresh lock.
   task run_lock_handoff();
      int crowd;
      int rounds;
      int pick;
      crowd = ($urandom_range(0, 6) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
      rounds = 0;
      issue_request(ACT_LOCK, TID_W'($urandom_range(0, 255)));
      repeat (crowd) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) issue_request(ACT_LOCK, TID_W'($urandom_range(0, 255)));
         else if (pick < 9) issue_request(ACT_TRYLOCK, TID_W'($urandom_range(0, 255)));
         else issue_request(ACT_DESTROY, TID_W'($urandom_range(0, 255)));
      end
      while (shadow.holder_valid && rounds < 60) begin
         rounds++;
         pick = $urandom_range(0, 39);
         if (pick < 2) begin
            issue_request(ACT_UNLOCK, shadow.holder ^ TID_W'($urandom_range(1, 255)));
         end else if (pick < 4) begin
            issue_request(ACT_LOCK, TID_W'($urandom_range(0, 255)));
         end else if (pick == 4) begin
            issue_request(ACT_INIT, TID_W'($urandom_range(0, 255)));
         end else begin
            issue_request(ACT_UNLOCK, shadow.holder);
            if (shadow.last_wake) issue_request(ACT_LOCK, shadow.last_woken);
         end
      end
      if ($urandom_range(0, 2) == 0) issue_request(ACT_DESTROY, TID_W'($urandom_range(0, 255)));
   endtask

   task run_stray_requests();
      repeat ($urandom_range(1, 8))
         issue_request(ACTION_BITS'($urandom_range(0, 7)), TID_W'($urandom_range(0, 255)));
   endtask

   initial begin
      shadow = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      issue_request(ACT_INIT, 8'h00);
      issue_request(ACT_UNLOCK, 8'h00);
      issue_request(ACT_DESTROY, 8'h00);
      issue_request(ACT_TRYLOCK, 8'hff);
      issue_request(ACT_TRYLOCK, 8'h00);
      issue_request(ACT_DESTROY, 8'hff);
      issue_request(ACT_UNLOCK, 8'hff);
      issue_request(ACT_LOCK, 8'h00);
      // The owner asking again is simply queued behind itself.
      issue_request(ACT_LOCK, 8'h00);
      repeat (WAITER_DEPTH - 1) issue_request(ACT_LOCK, TID_W'($urandom_range(0, 255)));
      issue_request(ACT_LOCK, 8'hff);
      issue_request(ACT_UNLOCK, 8'h00);
      issue_request(3'd5, 8'haa);
      issue_request(3'd7, 8'h55);
      issue_request(ACT_INIT, 8'hff);
      wait_answers_drained();

      while (shadow.request_count < ITEM_TARGET) begin
         if ($urandom_range(0, 11) == 0) steady_flow = !steady_flow;
         if ($urandom_range(0, 14) == 0) wait_answers_drained();
         if ($urandom_range(0, 9) < 7) run_lock_handoff();
         else run_stray_requests();
      end

      wait_answers_drained();
      repeat (4) @(posedge clock);
      if (shadow.due_answers.size() != 0)
         shadow.report_mismatch($sformatf("%0d results never arrived",
                                          shadow.due_answers.size()));
      $display("covered %0d requests and %0d results: %0d wakes, %0d blocked, %0d busy",
               shadow.request_count, shadow.answer_count, shadow.wake_count,
               shadow.status_seen[ST_BLOCKED], shadow.status_seen[ST_BUSY]);
      $display("also %0d stack-full, %0d not-owner and %0d in-use answers",
               shadow.status_seen[ST_FULL], shadow.status_seen[ST_NOT_OWNER],
               shadow.status_seen[ST_IN_USE]);
      if (shadow.error_count == 0) begin
         $display("mutex_with_waiter_stack_core_tb: clean");
      end else begin
         $display("mutex_with_waiter_stack_core_tb: errors");
      end
      $finish;
   end

endmodule
